// ----- rtl/htr_pkg.sv -----
package htr_pkg;

   // Sensor plausibility window, raw units (both limits are errors)
   localparam logic signed [15:0] SENSOR_LOW_LIMIT  = -16'sd500;
   localparam logic signed [15:0] SENSOR_HIGH_LIMIT = 16'sd1300;

   // Restart delay scaling
   localparam logic [15:0] MS_PER_MINUTE = 16'd60000;

   // Over-temperature limit after reset
   localparam logic signed [11:0] OVERTEMP_LIMIT_RESET = 12'sd2000;

   // Register indexes on the csr port
   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W  = 12;
   localparam logic [CSR_INDEX_W-1:0] REG_MODE_COOL      = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_TARGET_TEMP    = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_HYSTERESIS     = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_CALIB_OFFSET   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_OVERTEMP_LIMIT = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_RESTART_DELAY  = 3'd5;

   typedef enum logic [1:0] {
      STATUS_NORMAL = 2'd0,
      STATUS_SENSOR = 2'd1,
      STATUS_ALARM  = 2'd2
   } status_type;

   typedef struct packed {
      logic               mode_cool;
      logic signed [11:0] target_temp;
      logic [7:0]         hysteresis;
      logic signed [9:0]  calib_offset;
      logic signed [11:0] overtemp_limit;
      logic [7:0]         restart_delay_min;
   } htr_cfg_type;

   typedef struct packed {
      logic               relay_drive;
      logic [31:0]        off_ts;
      logic signed [15:0] held_temp;
   } htr_state_type;

endpackage

// ----- rtl/htr_chan_if.sv -----
// Sample channel
interface htr_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] sensor_raw;
   logic [31:0]        now_ms;

   modport source (output valid, output sensor_raw, output now_ms, input ready);
   modport sink   (input valid, input sensor_raw, input now_ms, output ready);
endinterface

// Result channel
interface htr_rsp_if;
   logic               valid;
   logic               ready;
   logic               relay_drive;
   logic [1:0]         status;
   logic signed [15:0] calibrated_temp;

   modport source (output valid, output relay_drive, output status, output calibrated_temp,
                   input ready);
   modport sink   (input valid, input relay_drive, input status, input calibrated_temp,
                   output ready);
endinterface

// ----- rtl/htr_eval.sv -----
module htr_eval (
   input  htr_pkg::htr_cfg_type   cfg,
   input  htr_pkg::htr_state_type state_cur,
   input  logic signed [15:0]     sensor_raw,
   input  logic [31:0]            now_ms,
   output htr_pkg::htr_state_type state_nxt,
   output htr_pkg::status_type    status
);
   import htr_pkg::*;

   logic               sensor_err;
   logic signed [15:0] sum;
   logic signed [16:0] held_x;
   logic signed [16:0] alarm_x;
   logic signed [13:0] tgt_w;
   logic signed [13:0] band_lo;
   logic signed [13:0] band_hi;
   logic signed [16:0] tgt_x;
   logic signed [16:0] lo_x;
   logic signed [16:0] hi_x;
   logic               alarm;
   logic               req_on;
   logic               req_off;
   logic [31:0]        elapsed;
   logic [23:0]        need_ms;
   logic               delay_ok;

   // Plausibility check and calibration
   assign sensor_err = (sensor_raw <= SENSOR_LOW_LIMIT) || (sensor_raw >= SENSOR_HIGH_LIMIT);
   assign sum        = sensor_raw + {{6{cfg.calib_offset[9]}}, cfg.calib_offset};
   assign held_x     = {sum[15], sum};
   assign alarm_x    = {{5{cfg.overtemp_limit[11]}}, cfg.overtemp_limit};
   assign alarm      = held_x >= alarm_x;

   // Hysteresis band edges
   assign tgt_w   = {{2{cfg.target_temp[11]}}, cfg.target_temp};
   assign band_lo = tgt_w - {6'd0, cfg.hysteresis};
   assign band_hi = tgt_w + {6'd0, cfg.hysteresis};
   assign tgt_x   = {{3{tgt_w[13]}}, tgt_w};
   assign lo_x    = {{3{band_lo[13]}}, band_lo};
   assign hi_x    = {{3{band_hi[13]}}, band_hi};

   // Restart delay, elapsed time wraps mod 2^32
   assign need_ms  = 24'(cfg.restart_delay_min) * 24'(MS_PER_MINUTE);
   assign elapsed  = now_ms - state_cur.off_ts;
   assign delay_ok = elapsed >= {8'd0, need_ms};

   // Relay requests
   always_comb begin
      status  = STATUS_NORMAL;
      req_on  = 1'b0;
      req_off = 1'b0;
      if (sensor_err) begin
         status  = STATUS_SENSOR;
         req_off = 1'b1;
      end else if (alarm) begin
         status  = STATUS_ALARM;
         req_off = 1'b1;
      end else if (!cfg.mode_cool) begin
         if (held_x <= lo_x) begin
            req_on = 1'b1;
         end else if (held_x >= tgt_x) begin
            req_off = 1'b1;
         end
      end else begin
         if (held_x >= hi_x) begin
            req_on = 1'b1;
         end else if (held_x <= tgt_x) begin
            req_off = 1'b1;
         end
      end
   end

   // Next relay state, off stamp and held temperature
   always_comb begin
      state_nxt = state_cur;
      if (!sensor_err) begin
         state_nxt.held_temp = sum;
      end
      if (req_off && state_cur.relay_drive) begin
         state_nxt.relay_drive = 1'b0;
         state_nxt.off_ts      = now_ms;
      end else if (req_on && !state_cur.relay_drive && delay_ok) begin
         state_nxt.relay_drive = 1'b1;
      end
   end

endmodule

// ----- rtl/hysteresis_thermostat_relay.sv -----
// Channel  Dir  Handshake          Word
// req_if   in   valid/ready        sensor_raw (s16), now_ms (u32)
// rsp_if   out  valid/ready        relay_drive (1), status (2), calibrated_temp (s16)
// csr      in   csr_we, no wait    csr_index (3), csr_wdata (12)
//
// One word per cycle sustained while the result register can drain; a sample taken into
// the input stage moves on from there to the result register.
// The relay, off stamp and held temperature are computed combinationally in htr_eval and registered in state_ff.
// Reset (synchronous) clears the stages and state; the over-temperature limit comes up at 2000.
// An input stage and the result register decouple the sides: req_if.ready drops
// only when both hold a word and rsp_if.ready is low.
module hysteresis_thermostat_relay (
   input  logic                                 clock,
   input  logic                                 reset,
   htr_req_if.sink                              req_if,
   htr_rsp_if.source                            rsp_if,
   input  logic                                 csr_we,
   input  logic [htr_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [htr_pkg::CSR_DATA_W-1:0]       csr_wdata
);
   import htr_pkg::*;

   htr_cfg_type        cfg_ff, cfg_in;
   htr_state_type      state_ff, state_in;
   htr_state_type      state_eval;
   status_type         status_eval;

   logic               s1_valid_ff, s1_valid_in;
   logic signed [15:0] s1_raw_ff, s1_raw_in;
   logic [31:0]        s1_now_ff, s1_now_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_relay_ff, rsp_relay_in;
   status_type         rsp_status_ff, rsp_status_in;
   logic signed [15:0] rsp_temp_ff, rsp_temp_in;

   logic               out_open;
   logic               s1_move;
   logic               req_take;

   // Configuration writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            REG_MODE_COOL:      cfg_in.mode_cool         = csr_wdata[0];
            REG_TARGET_TEMP:    cfg_in.target_temp       = csr_wdata[11:0];
            REG_HYSTERESIS:     cfg_in.hysteresis        = csr_wdata[7:0];
            REG_CALIB_OFFSET:   cfg_in.calib_offset      = csr_wdata[9:0];
            REG_OVERTEMP_LIMIT: cfg_in.overtemp_limit    = csr_wdata[11:0];
            REG_RESTART_DELAY:  cfg_in.restart_delay_min = csr_wdata[7:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   // Flow control
   assign out_open      = !rsp_valid_ff || rsp_if.ready;
   assign s1_move       = s1_valid_ff && out_open;
   assign req_if.ready  = !s1_valid_ff || out_open;
   assign req_take      = req_if.valid && req_if.ready;

   // Input stage
   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_raw_in   = s1_raw_ff;
      s1_now_in   = s1_now_ff;
      if (req_if.ready) begin
         s1_valid_in = req_if.valid;
      end
      if (req_take) begin
         s1_raw_in = req_if.sensor_raw;
         s1_now_in = req_if.now_ms;
      end
   end

   htr_eval u_eval (
      .cfg        (cfg_ff),
      .state_cur  (state_ff),
      .sensor_raw (s1_raw_ff),
      .now_ms     (s1_now_ff),
      .state_nxt  (state_eval),
      .status     (status_eval)
   );

   // State and result register
   always_comb begin
      state_in      = state_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_relay_in  = rsp_relay_ff;
      rsp_status_in = rsp_status_ff;
      rsp_temp_in   = rsp_temp_ff;
      if (out_open) begin
         rsp_valid_in = s1_valid_ff;
      end
      if (s1_move) begin
         state_in      = state_eval;
         rsp_relay_in  = state_eval.relay_drive;
         rsp_status_in = status_eval;
         rsp_temp_in   = state_eval.held_temp;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mode_cool         <= 1'b0;
         cfg_ff.target_temp       <= '0;
         cfg_ff.hysteresis        <= '0;
         cfg_ff.calib_offset      <= '0;
         cfg_ff.overtemp_limit    <= OVERTEMP_LIMIT_RESET;
         cfg_ff.restart_delay_min <= '0;
         state_ff                 <= '0;
         s1_valid_ff              <= 1'b0;
         rsp_valid_ff             <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         state_ff     <= state_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_raw_ff     <= s1_raw_in;
      s1_now_ff     <= s1_now_in;
      rsp_relay_ff  <= rsp_relay_in;
      rsp_status_ff <= rsp_status_in;
      rsp_temp_ff   <= rsp_temp_in;
   end

   assign rsp_if.valid           = rsp_valid_ff;
   assign rsp_if.relay_drive     = rsp_relay_ff;
   assign rsp_if.status          = rsp_status_ff;
   assign rsp_if.calibrated_temp = rsp_temp_ff;

   // A fault or alarm word never reports the relay on
   a_fault_relay_off: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_status_ff != STATUS_NORMAL)) |-> !rsp_relay_ff)
      else $error("relay on with fault or alarm status");

   // Off stamp moves only together with a turn-off
   a_stamp_on_fall: assert property (@(posedge clock) disable iff (reset)
      (state_ff.off_ts != $past(state_ff.off_ts)) |-> $fell(state_ff.relay_drive))
      else $error("off stamp changed without turn-off");

   // Turn-on honors the restart delay
   a_turn_on_delay: assert property (@(posedge clock) disable iff (reset)
      $rose(state_ff.relay_drive) |->
         ($past(s1_now_ff - state_ff.off_ts) >=
          {8'd0, $past(24'(cfg_ff.restart_delay_min) * 24'(MS_PER_MINUTE))}))
      else $error("relay turned on before restart delay");

   // State moves only when a word goes to the result register
   a_state_on_move: assert property (@(posedge clock) disable iff (reset)
      !s1_move |=> $stable(state_ff))
      else $error("state changed without a word");

   // An empty result register never stalls the input
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid_ff |-> req_if.ready)
      else $error("input stalled with empty output");

endmodule
